/* src/mhcs_pkg.sv */
// Shared types and constants for the mail header comment splitter.
// No dependencies; compiled first.
`default_nettype none

package mhcs_pkg;

	localparam int unsigned MAX_NEST_DEF = 255;

	// Length saturation point, capped to the 16-bit length fields
	localparam longint unsigned MAX_LENGTH = 65535;
	localparam logic [15:0] LEN_LIMIT =
		(MAX_LENGTH < 64'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_VALUE   = 2'd0,
		KIND_COMMENT = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Everything one input byte can produce: a value byte, a comment byte and
	// the end marker, always delivered in that order
	typedef struct packed {
		logic        v_emit;
		logic        c_emit;
		logic        mark;
		logic [7:0]  v_byte;
		logic [7:0]  c_byte;
		logic [15:0] v_len;
		logic [15:0] c_len;
	} bnd_t;

	function automatic logic is_white(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
	endfunction

endpackage

`default_nettype wire

/* src/mhcs_if.sv */
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on mhcs_pkg.
`default_nettype none

interface mhcs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_field;

	modport source(output valid, data_byte, end_of_field, input ready);
	modport sink(input valid, data_byte, end_of_field, output ready);
endinterface

interface mhcs_res_if;
	logic                valid;
	logic                ready;
	mhcs_pkg::kind_t     kind;
	logic [7:0]          out_byte;
	logic [15:0]         value_length;
	logic [15:0]         comment_length;
	logic                last_of_run;

	modport source(output valid, kind, out_byte, value_length, comment_length,
		last_of_run, input ready);
	modport sink(input valid, kind, out_byte, value_length, comment_length,
		last_of_run, output ready);
endinterface

`default_nettype wire

/* src/mhcs_parser.sv */
// Input register, field state and the per-byte routing logic.
// Depends on mhcs_pkg and mhcs_char_if.
`default_nettype none

module mhcs_parser #(
	parameter int unsigned MAX_NEST = mhcs_pkg::MAX_NEST_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mhcs_char_if.sink     chars,
	input  logic          take,
	output logic          proc,
	output mhcs_pkg::bnd_t bnd
);
	import mhcs_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_NEST + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;

	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic               in_quote_q, in_quote_d;
	logic               esc_q, esc_d;
	logic               stopped_q, stopped_d;
	logic               lead_q, lead_d;
	logic               vtail_q, vtail_n;
	logic               ctail_q, ctail_n;
	logic [15:0]        vcnt_q, vcnt_n;
	logic [15:0]        ccnt_q, ccnt_n;

	logic               cur;
	logic               cnt_zero;
	logic               tail;
	logic               emit_cur;
	logic               v_emit, c_emit;
	logic [7:0]         v_byte, c_byte;

	assign chars.ready = !valid_s1 || take;
	assign proc        = valid_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1 <= chars.data_byte;
			last_s1 <= chars.end_of_field;
		end
	end

	always_comb begin
		cur        = depth_q != '0;
		cnt_zero   = cur ? (ccnt_q == '0) : (vcnt_q == '0);
		tail       = cur ? ctail_q : vtail_q;
		depth_d    = depth_q;
		in_quote_d = in_quote_q;
		esc_d      = esc_q;
		stopped_d  = stopped_q;
		lead_d     = lead_q;
		emit_cur   = 1'b0;
		v_emit     = 1'b0;
		c_emit     = 1'b0;
		v_byte     = byte_s1;
		c_byte     = byte_s1;

		if (stopped_q) begin
			// rest of the field after a NUL is ignored
		end else if (!lead_q && is_white(byte_s1)) begin
			// leading whitespace skipped
		end else begin
			lead_d = 1'b1;
			if (byte_s1 == CH_NUL) begin
				stopped_d = 1'b1;
				esc_d     = 1'b0;
			end else if (esc_q) begin
				esc_d    = 1'b0;
				emit_cur = 1'b1;
			end else begin
				case (byte_s1)
					CH_BSLASH: begin
						if ((in_quote_q || cur) && !last_s1) esc_d = 1'b1;
					end
					CH_QUOTE: begin
						in_quote_d = !in_quote_q;
						emit_cur   = 1'b1;
					end
					CH_OPEN: begin
						if (!in_quote_q) begin
							if (!cur) begin
								// separator space on each non-empty stream not already ending in a space
								v_emit = (vcnt_q != '0) && !vtail_q;
								v_byte = CH_SPACE;
								c_emit = (ccnt_q != '0) && !ctail_q;
								c_byte = CH_SPACE;
							end else begin
								c_emit = 1'b1;
							end
							if (depth_q < DEPTH_MAX) depth_d = depth_q + DEPTH_ONE;
						end else begin
							emit_cur = 1'b1;
						end
					end
					CH_CLOSE: begin
						if (!in_quote_q && cur) begin
							depth_d = depth_q - DEPTH_ONE;
							c_emit  = depth_q != DEPTH_ONE;
						end else begin
							emit_cur = 1'b1;
						end
					end
					CH_SPACE, CH_TAB: begin
						if (in_quote_q || !(cnt_zero || tail)) emit_cur = 1'b1;
					end
					default: begin
						emit_cur = 1'b1;
					end
				endcase
			end
		end

		if (emit_cur) begin
			if (cur) c_emit = 1'b1;
			else v_emit = 1'b1;
		end

		vcnt_n  = (v_emit && vcnt_q < LEN_LIMIT) ? vcnt_q + 16'd1 : vcnt_q;
		ccnt_n  = (c_emit && ccnt_q < LEN_LIMIT) ? ccnt_q + 16'd1 : ccnt_q;
		vtail_n = v_emit ? (v_byte == CH_SPACE) : vtail_q;
		ctail_n = c_emit ? (c_byte == CH_SPACE) : ctail_q;
	end

	always_comb begin
		bnd.v_emit = v_emit;
		bnd.c_emit = c_emit;
		bnd.mark   = last_s1;
		bnd.v_byte = v_byte;
		bnd.c_byte = c_byte;
		bnd.v_len  = vcnt_n;
		bnd.c_len  = ccnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			in_quote_q <= 1'b0;
			esc_q      <= 1'b0;
			stopped_q  <= 1'b0;
			lead_q     <= 1'b0;
			vtail_q    <= 1'b0;
			ctail_q    <= 1'b0;
			vcnt_q     <= '0;
			ccnt_q     <= '0;
		end else if (proc) begin
			if (last_s1) begin
				depth_q    <= '0;
				in_quote_q <= 1'b0;
				esc_q      <= 1'b0;
				stopped_q  <= 1'b0;
				lead_q     <= 1'b0;
				vtail_q    <= 1'b0;
				ctail_q    <= 1'b0;
				vcnt_q     <= '0;
				ccnt_q     <= '0;
			end else begin
				depth_q    <= depth_d;
				in_quote_q <= in_quote_d;
				esc_q      <= esc_d;
				stopped_q  <= stopped_d;
				lead_q     <= lead_d;
				vtail_q    <= vtail_n;
				ctail_q    <= ctail_n;
				vcnt_q     <= vcnt_n;
				ccnt_q     <= ccnt_n;
			end
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("nesting depth above its limit");

	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> depth_q == '0 && vcnt_q == '0 && ccnt_q == '0
			&& !in_quote_q && !lead_q)
		else $error("state not cleared after end of field");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input register changed");

endmodule

`default_nettype wire

/* src/mhcs_serializer.sv */
// Result register: holds the results of one byte and hands them out one
// transaction per cycle while the sink is ready. Depends on mhcs_pkg and mhcs_res_if.
`default_nettype none

module mhcs_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           proc,
	input  mhcs_pkg::bnd_t bnd,
	output logic           take,
	mhcs_res_if.source     results
);
	import mhcs_pkg::*;

	// bit 0 value byte, bit 1 comment byte, bit 2 end marker
	logic [2:0]  pending_q;
	logic [2:0]  sel;
	logic [7:0]  v_byte_q, c_byte_q;
	logic [15:0] v_len_q, c_len_q;
	logic        xfer;

	assign sel  = pending_q & (~pending_q + 3'd1);
	assign xfer = results.valid && results.ready;
	assign take = (pending_q == '0) || ($onehot(pending_q) && results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (proc) begin
			pending_q <= {bnd.mark, bnd.c_emit, bnd.v_emit};
		end else if (xfer) begin
			pending_q <= pending_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			v_byte_q <= bnd.v_byte;
			c_byte_q <= bnd.c_byte;
			v_len_q  <= bnd.v_len;
			c_len_q  <= bnd.c_len;
		end
	end

	always_comb begin
		results.valid          = pending_q != '0;
		results.last_of_run    = pending_q == sel;
		results.kind           = KIND_END;
		results.out_byte       = '0;
		results.value_length   = '0;
		results.comment_length = '0;
		if (sel[0]) begin
			results.kind     = KIND_VALUE;
			results.out_byte = v_byte_q;
		end else if (sel[1]) begin
			results.kind     = KIND_COMMENT;
			results.out_byte = c_byte_q;
		end else begin
			results.value_length   = v_len_q;
			results.comment_length = c_len_q;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		proc |-> pending_q == '0 || ($onehot(pending_q) && results.ready))
		else $error("result register overwritten while results pending");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> pending_q == $past(pending_q))
		else $error("pending results changed under stall");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && results.last_of_run |=>
			results.valid == $past(proc && (bnd.v_emit || bnd.c_emit || bnd.mark)))
		else $error("results left over after last of run");

endmodule

`default_nettype wire

/* src/mail_header_comment_splitter.sv */
// An accepted byte passes the input register and parser logic into the
// result register, which offers its results. Throughput: one byte per
// cycle while each byte yields at most one result and the port is ready;
// otherwise the result register is held until each result is taken.
// Reset (arst_n low) clears the field state and both pipeline stages.
// Top level; depends on mhcs_pkg, mhcs_if, mhcs_parser, mhcs_serializer.
`default_nettype none

module mail_header_comment_splitter #(
	parameter int unsigned MAX_NEST = mhcs_pkg::MAX_NEST_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mhcs_char_if.sink  chars,
	mhcs_res_if.source results
);
	import mhcs_pkg::*;

	logic take;
	logic proc;
	bnd_t bnd;

	mhcs_parser #(
		.MAX_NEST(MAX_NEST)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.take  (take),
		.proc  (proc),
		.bnd   (bnd)
	);

	mhcs_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.bnd    (bnd),
		.take   (take),
		.results(results)
	);

endmodule

`default_nettype wire
